### rtl/core/trst_pkg.sv
// Shared types, constants and helpers for the triangle refinement size test.
// No dependencies; imported by every module of the block.
package trst_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int FRAC_BITS_DEF  = 16;

    // register stages in the point evaluator
    localparam int EVAL_LAT = 5;

    // stream widths
    localparam int IN_W  = 296;
    localparam int OUT_W = 8;

    // operation codes (s_tuser)
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_GRADIENT    = 2'd0;
    localparam logic [1:0] CFG_MESH_SIZE   = 2'd1;
    localparam logic [1:0] CFG_POINT_COUNT = 2'd2;

    // one refinement point as held in a ring cell
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [30:0]        size;
    } trst_point_t;

    // per-test constants handed to the evaluator
    typedef struct packed {
        logic signed [33:0] cx3;
        logic signed [33:0] cy3;
        logic [61:0]        msq;
        logic [61:0]        gsq;
        logic [127:0]       lhs;
    } trst_test_t;

    // join four 31x31 partial products of a 62x62 product
    function automatic logic [127:0] comb_62(input logic [61:0] ll, input logic [61:0] lh,
                                             input logic [61:0] hl, input logic [61:0] hh);
        comb_62 = 128'(ll) + (128'(lh) << 31) + (128'(hl) << 31) + (128'(hh) << 62);
    endfunction

endpackage

### rtl/core/triangle_refinement_size_test.sv
// Top level of the triangle refinement size test: stream ports, config
// registers, test sequencer, point ring and evaluator. Depends on trst_pkg, trst_cell and trst_eval.
//
// Usage:
//   s_* carries one beat per item; s_tuser selects load (0) or test (1).
//   A load writes ring cell entry_index and gives no result;
//   slots at or beyond MAX_POINTS are ignored.
//   A test gives one beat on m_* with m_tdata[0] = unsuitable.
//   cfg_* writes gradient (0), mesh_size (1), point_count (2); always ready,
//   to be used only while the block is idle.
// Sequencing:
//   A test that the mean edge bound alone does not decide turns the ring of
//   point cells one full turn, one entry into the evaluator pipeline per
//   cycle; when that bound alone decides, the turn is skipped. Items, loads
//   as well as tests, are accepted only while the block is idle.
// Reset:
//   Clears control state and sets gradient and mesh_size to 1.0, count 0.
//   The table holds no defined contents until loaded.
// Stall:
//   The result waits in the output register; a further test still runs and
//   holds its result until the register is free.
module triangle_refinement_size_test #(
    parameter int MAX_POINTS = trst_pkg::MAX_POINTS_DEF,
    parameter int FRAC_BITS  = trst_pkg::FRAC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // entry_index[5:0] point_x[37:6] point_y[69:38] point_size[100:70]
    // org_x[132:101] org_y[164:133] dest_x[196:165] dest_y[228:197]
    // apex_x[260:229] apex_y[292:261], zero fill above
    input  logic [trst_pkg::IN_W-1:0] s_tdata,
    // operation[0]
    input  logic                      s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // unsuitable[0], zero fill above
    output logic [trst_pkg::OUT_W-1:0] m_tdata,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [30:0]               cfg_data
);
    import trst_pkg::*;

    localparam int CNT_END = MAX_POINTS + EVAL_LAT - 1;
    localparam int CNT_W   = $clog2(CNT_END + 2);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_LHS  = 3'd3;
    localparam logic [2:0] ST_LHS2 = 3'd4;
    localparam logic [2:0] ST_RUN  = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             hit_reg, hit_next;
    logic             m_tvalid_reg, unsuit_reg;
    logic [30:0]      gradient_reg, mesh_size_reg;
    logic [6:0]       point_count_reg;
    logic [CNT_W-1:0] n_lim;

    logic             in_fire, load_fire, out_load, shift_en, pt_valid, eval_hit;
    trst_point_t      wr_pt;
    trst_point_t      ring_pt [MAX_POINTS];
    trst_test_t       tc;

    logic signed [31:0] ox_reg, oy_reg, dx_reg, dy_reg, ax_reg, ay_reg;
    logic [65:0]        sq_reg [6];
    logic [68:0]        s_reg;
    logic [63:0]        lim_reg;
    logic [63:0]        lp_ll_reg, lp_hl_reg;
    logic [61:0]        lp_lh_reg, lp_hh_reg;
    logic [32:0]        ad [6];

    // magnitude of a vertex coordinate difference
    function automatic logic [32:0] abs_diff(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
        logic signed [32:0] d;
        d = $signed(33'(a)) - $signed(33'(b));
        abs_diff = d[32] ? 33'(-d) : 33'(d);
    endfunction

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;
    assign load_fire = in_fire && (s_tuser == OP_LOAD);
    assign out_load  = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);
    assign shift_en  = (state_reg == ST_RUN) && (32'(cnt_reg) < MAX_POINTS);
    assign n_lim     = (32'(point_count_reg) > MAX_POINTS) ? CNT_W'(MAX_POINTS)
                                                           : CNT_W'(point_count_reg);
    assign pt_valid  = (state_reg == ST_RUN) && (cnt_reg < n_lim);

    assign wr_pt.x    = s_tdata[37:6];
    assign wr_pt.y    = s_tdata[69:38];
    assign wr_pt.size = s_tdata[100:70];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gradient_reg    <= 31'd65536;
            mesh_size_reg   <= 31'd65536;
            point_count_reg <= 7'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_GRADIENT:    gradient_reg    <= cfg_data;
                CFG_MESH_SIZE:   mesh_size_reg   <= cfg_data;
                CFG_POINT_COUNT: point_count_reg <= cfg_data[6:0];
                default:         ;
            endcase
        end
    end

    // point ring
    for (genvar i = 0; i < MAX_POINTS; i++)
    begin : g_ring
        trst_cell u_cell (
            .clk      (clk),
            .wr_en    (load_fire && (32'(s_tdata[5:0]) == i)),
            .wr_pt    (wr_pt),
            .shift_en (shift_en),
            .nbr      (ring_pt[(i + 1) % MAX_POINTS]),
            .pt       (ring_pt[i])
        );
    end

    trst_eval #(
        .FRAC_BITS (FRAC_BITS)
    ) u_eval (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pt_valid),
        .pt       (ring_pt[0]),
        .tc       (tc),
        .hit      (eval_hit)
    );

    // edge magnitudes: org-apex, dest-apex, org-dest
    always_comb
    begin
        ad[0] = abs_diff(ox_reg, ax_reg);
        ad[1] = abs_diff(oy_reg, ay_reg);
        ad[2] = abs_diff(dx_reg, ax_reg);
        ad[3] = abs_diff(dy_reg, ay_reg);
        ad[4] = abs_diff(ox_reg, dx_reg);
        ad[5] = abs_diff(oy_reg, dy_reg);
    end

    // test setup datapath
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ox_reg <= s_tdata[132:101];
            oy_reg <= s_tdata[164:133];
            dx_reg <= s_tdata[196:165];
            dy_reg <= s_tdata[228:197];
            ax_reg <= s_tdata[260:229];
            ay_reg <= s_tdata[292:261];
        end
        if (state_reg == ST_SQ)
        begin
            for (int k = 0; k < 6; k++)
            begin
                sq_reg[k] <= 66'(ad[k]) * 66'(ad[k]);
            end
            tc.msq <= 62'(mesh_size_reg) * 62'(mesh_size_reg);
            tc.gsq <= 62'(gradient_reg) * 62'(gradient_reg);
            tc.cx3 <= 34'(ox_reg) + 34'(dx_reg) + 34'(ax_reg);
            tc.cy3 <= 34'(oy_reg) + 34'(dy_reg) + 34'(ay_reg);
        end
        if (state_reg == ST_SUM)
        begin
            s_reg   <= 69'(sq_reg[0]) + 69'(sq_reg[1]) + 69'(sq_reg[2])
                     + 69'(sq_reg[3]) + 69'(sq_reg[4]) + 69'(sq_reg[5]);
            lim_reg <= 64'(tc.msq) * 64'd3;
        end
        if (state_reg == ST_LHS)
        begin
            lp_ll_reg <= 64'(s_reg[31:0])  * 64'(tc.gsq[31:0]);
            lp_lh_reg <= 62'(s_reg[31:0])  * 62'(tc.gsq[61:32]);
            lp_hl_reg <= 64'(s_reg[63:32]) * 64'(tc.gsq[31:0]);
            lp_hh_reg <= 62'(s_reg[63:32]) * 62'(tc.gsq[61:32]);
        end
        if (state_reg == ST_LHS2)
        begin
            tc.lhs <= 128'((128'(lp_ll_reg) + (128'(lp_lh_reg) << 32)
                          + (128'(lp_hl_reg) << 32) + (128'(lp_hh_reg) << 64)) * 128'd3);
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        hit_next   = hit_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (s_tuser == OP_TEST))
                begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ:   state_next = ST_SUM;
            ST_SUM:  state_next = ST_LHS;
            ST_LHS:
            begin
                // mean edge bound alone decides
                if (s_reg > 69'(lim_reg))
                begin
                    hit_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    hit_next   = 1'b0;
                    state_next = ST_LHS2;
                end
            end
            ST_LHS2:
            begin
                cnt_next   = '0;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                hit_next = hit_reg | eval_hit;
                cnt_next = cnt_reg + 1'b1;
                if (32'(cnt_reg) == CNT_END)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            hit_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            hit_reg   <= hit_next;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            unsuit_reg <= hit_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(OUT_W - 1)'(0), unsuit_reg};

    // evaluator hits only come back while the ring turns
    a_hit_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        eval_hit |-> (state_reg == ST_RUN))
        else $error("evaluator hit outside ring turn");

    // a finished test always lands in the output register
    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_tvalid)
        else $error("result not presented");

    // ring turn counter stays within its run
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (32'(cnt_reg) <= CNT_END))
        else $error("ring counter overran");

    // ring moves only during a test, never together with a load
    a_shift_load: assert property (@(posedge clk) disable iff (!rst_n)
        shift_en |-> !in_fire)
        else $error("ring shift during accepted item");

endmodule

### rtl/core/trst_cell.sv
// One cell of the refinement point ring: holds a table entry, takes a load
// or the entry of its neighbor. Depends on trst_pkg.
module trst_cell (
    input  logic               clk,
    input  logic               wr_en,
    input  trst_pkg::trst_point_t wr_pt,
    input  logic               shift_en,
    input  trst_pkg::trst_point_t nbr,
    output trst_pkg::trst_point_t pt
);
    import trst_pkg::*;

    trst_point_t pt_reg;

    // load has priority; loads only happen while the ring is at rest
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pt_reg <= wr_pt;
        end
        else if (shift_en)
        begin
            pt_reg <= nbr;
        end
    end

    assign pt = pt_reg;

endmodule

### rtl/core/trst_eval.sv
// Pipelined per-point gradient test: one ring entry enters per cycle, its hit
// flag leaves through stages 1 to 4 and the hit register. Depends on trst_pkg.
module trst_eval #(
    parameter int FRAC_BITS = trst_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  trst_pkg::trst_point_t pt,
    input  trst_pkg::trst_test_t  tc,
    output logic                  hit
);
    import trst_pkg::*;

    logic               v1_reg, v2_reg, v3_reg, v4_reg, hit_reg;
    logic signed [34:0] ddx, ddy;
    logic [34:0]        mx1_next, my1_next;
    logic [34:0]        mx1_reg, my1_reg;
    logic [61:0]        rsq1_reg;
    logic [69:0]        sqx2_reg, sqy2_reg;
    logic               skip2_reg, skip3_reg, skip4_reg;
    logic [61:0]        dm2_reg;
    logic [61:0]        rg_ll2_reg, rg_lh2_reg, rg_hl2_reg, rg_hh2_reg;
    logic [61:0]        zn_ll3_reg, zn_lh3_reg, zn_hl3_reg, zn_hh3_reg;
    logic [127:0]       d9s3_reg, rg3_reg;
    logic [127:0]       d9s4_reg, zone4_reg, rhs4_reg;

    // centroid-to-point offsets, all times three
    always_comb
    begin
        ddx = $signed(35'(tc.cx3)) - $signed(35'(pt.x)) * 35'sd3;
        ddy = $signed(35'(tc.cy3)) - $signed(35'(pt.y)) * 35'sd3;
        mx1_next = ddx[34] ? 35'(-ddx) : 35'(ddx);
        my1_next = ddy[34] ? 35'(-ddy) : 35'(ddy);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            hit_reg <= 1'b0;
        end
        else
        begin
            v1_reg  <= in_valid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            hit_reg <= v4_reg && !skip4_reg && (zone4_reg > d9s4_reg) && (tc.lhs > rhs4_reg);
        end
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        // stage 1: size square, offset magnitudes
        rsq1_reg <= 62'(pt.size) * 62'(pt.size);
        mx1_reg  <= mx1_next;
        my1_reg  <= my1_next;
        // stage 2: offset squares, zone difference, size^2 * gradient^2 partials
        sqx2_reg   <= 70'(mx1_reg) * 70'(mx1_reg);
        sqy2_reg   <= 70'(my1_reg) * 70'(my1_reg);
        skip2_reg  <= rsq1_reg >= tc.msq;
        dm2_reg    <= tc.msq - rsq1_reg;
        rg_ll2_reg <= 62'(rsq1_reg[30:0])  * 62'(tc.gsq[30:0]);
        rg_lh2_reg <= 62'(rsq1_reg[30:0])  * 62'(tc.gsq[61:31]);
        rg_hl2_reg <= 62'(rsq1_reg[61:31]) * 62'(tc.gsq[30:0]);
        rg_hh2_reg <= 62'(rsq1_reg[61:31]) * 62'(tc.gsq[61:31]);
        // stage 3: scaled distance, size term, zone partials
        d9s3_reg   <= (128'(sqx2_reg) + 128'(sqy2_reg)) << (2 * FRAC_BITS);
        rg3_reg    <= comb_62(rg_ll2_reg, rg_lh2_reg, rg_hl2_reg, rg_hh2_reg);
        skip3_reg  <= skip2_reg;
        zn_ll3_reg <= 62'(dm2_reg[30:0])  * 62'(tc.gsq[30:0]);
        zn_lh3_reg <= 62'(dm2_reg[30:0])  * 62'(tc.gsq[61:31]);
        zn_hl3_reg <= 62'(dm2_reg[61:31]) * 62'(tc.gsq[30:0]);
        zn_hh3_reg <= 62'(dm2_reg[61:31]) * 62'(tc.gsq[61:31]);
        // stage 4: zone bound and right-hand side, modulo 2^128
        zone4_reg <= 128'(comb_62(zn_ll3_reg, zn_lh3_reg, zn_hl3_reg, zn_hh3_reg) * 128'd9);
        rhs4_reg  <= d9s3_reg + 128'(rg3_reg * 128'd9);
        d9s4_reg  <= d9s3_reg;
        skip4_reg <= skip3_reg;
    end

    assign hit = hit_reg;

endmodule

### verif/triangle_refinement_size_test_tb.sv
// Testbench for the triangle refinement size test: loads refinement points,
// tests triangles and checks each verdict against a built-in predictor.
// Depends on trst_pkg and triangle_refinement_size_test.
module triangle_refinement_size_test_tb;
    import trst_pkg::*;

    localparam int NPTS = 64;

    typedef struct {
        logic               op;
        logic [5:0]         idx;
        logic signed [31:0] px, py;
        logic [30:0]        psize;
        logic signed [31:0] ox, oy, dx, dy, ax, ay;
    } tri_item_t;

    // verdict predictor and queue of expected verdicts
    class verdict_board;
        logic [30:0]        grad, msize;
        logic [6:0]         count;
        logic signed [31:0] tx [NPTS];
        logic signed [31:0] ty [NPTS];
        logic [30:0]        tsz [NPTS];
        bit                 want_q [$];
        int                 errors;

        function void init();
            grad = 31'd65536;
            msize = 31'd65536;
            count = 0;
            errors = 0;
            for (int i = 0; i < NPTS; i++)
            begin
                tx[i] = 0;
                ty[i] = 0;
                tsz[i] = 0;
            end
        endfunction

        function void set_reg(logic [1:0] idx, logic [30:0] val);
            if (idx == CFG_GRADIENT)
                grad = val;
            else if (idx == CFG_MESH_SIZE)
                msize = val;
            else if (idx == CFG_POINT_COUNT)
                count = val[6:0];
        endfunction

        function bit refine(tri_item_t it);
            logic [127:0] s, msq, gsq, rsq, d9s, zone, lhs, rhs;
            logic signed [35:0] cx3, cy3, ex, ey;
            logic signed [33:0] e0, e1, e2, e3, e4, e5;
            int n;
            e0 = it.ox - it.ax;
            e1 = it.oy - it.ay;
            e2 = it.dx - it.ax;
            e3 = it.dy - it.ay;
            e4 = it.ox - it.dx;
            e5 = it.oy - it.dy;
            s = 128'(e0) * 128'(e0) + 128'(e1) * 128'(e1) + 128'(e2) * 128'(e2)
                + 128'(e3) * 128'(e3) + 128'(e4) * 128'(e4) + 128'(e5) * 128'(e5);
            msq = 128'(msize) * 128'(msize);
            if (s > msq * 3)
                return 1;
            gsq = 128'(grad) * 128'(grad);
            cx3 = 36'(it.ox) + 36'(it.dx) + 36'(it.ax);
            cy3 = 36'(it.oy) + 36'(it.dy) + 36'(it.ay);
            n = (count < NPTS) ? count : NPTS;
            for (int v = 0; v < n && gsq != 0; v++)
            begin
                rsq = 128'(tsz[v]) * 128'(tsz[v]);
                if (rsq >= msq)
                    continue;
                ex = cx3 - 36'(tx[v]) * 3;
                ey = cy3 - 36'(ty[v]) * 3;
                d9s = (128'(ex) * 128'(ex) + 128'(ey) * 128'(ey)) << 32;
                zone = gsq * (msq - rsq) * 9;
                if (!(zone > d9s))
                    continue;
                lhs = s * gsq * 3;
                rhs = d9s + rsq * gsq * 9;
                if (lhs > rhs)
                    return 1;
            end
            return 0;
        endfunction

        function void note_input(tri_item_t it);
            if (it.op == OP_LOAD)
            begin
                tx[it.idx] = it.px;
                ty[it.idx] = it.py;
                tsz[it.idx] = it.psize;
            end
            else
                want_q.push_back(refine(it));
        endfunction

        // one line per mismatch, counted
        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_verdict(logic [OUT_W-1:0] got);
            if (want_q.size() == 0)
            begin
                report($sformatf("verdict %0d with none expected", got[0]));
                return;
            end
            if (got !== {7'd0, want_q[0]})
                report($sformatf("verdict %0h expected %0d", got, want_q[0]));
            void'(want_q.pop_front());
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_W-1:0]    m_tdata;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [1:0]          cfg_index;
    logic [30:0]         cfg_data;

    verdict_board board;
    bit   hold_rx;
    int   idle_cycles;

    triangle_refinement_size_test u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // send one item, after a random gap when gaps is set; valid stays up for a following beat
    task automatic send_item(tri_item_t it, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 11) : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.op;
        s_tdata <= {3'd0, it.ay, it.ax, it.dy, it.dx, it.oy, it.ox,
                    it.psize, it.py, it.px, it.idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_input(it);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [30:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.set_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // wait for every verdict, then hold the sender idle before going on
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.want_q.size() != 0)
            @(posedge clk);
        repeat (NPTS + 20) @(posedge clk);
    endtask

    // mostly small coordinates so both criteria come into play
    function automatic logic signed [31:0] coord(int span);
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed(32'($urandom_range(0, 2 * span))) - span;
        endcase
    endfunction

    function automatic tri_item_t rand_load(int span);
        tri_item_t it;
        it.op = OP_LOAD;
        it.idx = 6'($urandom_range(0, 63));
        it.px = coord(span);
        it.py = coord(span);
        it.psize = ($urandom_range(0, 5) == 0) ? 31'($urandom)
                                                : 31'($urandom_range(0, 2 * span));
        {it.ox, it.oy, it.dx, it.dy, it.ax, it.ay} = {$urandom, $urandom, $urandom,
                                                     $urandom, $urandom, $urandom};
        return it;
    endfunction

    function automatic tri_item_t rand_test(int span);
        tri_item_t it;
        it.op = OP_TEST;
        it.idx = 6'($urandom);
        it.px = $urandom;
        it.py = $urandom;
        it.psize = 31'($urandom);
        it.ox = coord(span);
        it.oy = coord(span);
        it.dx = it.ox + $signed(32'($urandom_range(0, span))) - span / 2;
        it.dy = it.oy + $signed(32'($urandom_range(0, span))) - span / 2;
        it.ax = it.ox + $signed(32'($urandom_range(0, span))) - span / 2;
        it.ay = it.oy + $signed(32'($urandom_range(0, span))) - span / 2;
        if ($urandom_range(0, 7) == 0)
        begin
            it.dx = coord(span);
            it.ay = coord(span);
        end
        return it;
    endfunction

    // load every slot so no read ever sees an unwritten cell
    task automatic fill_table(int span, bit gaps);
        tri_item_t it;
        for (int i = 0; i < NPTS; i++)
        begin
            it = rand_load(span);
            it.idx = 6'(i);
            send_item(it, gaps);
        end
    endtask

    // result side: random stalls, plus a long hold-off on request
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_rx)
            begin
                m_tready <= 1'b0;
                repeat (600) @(posedge clk);
                hold_rx = 0;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                stall = $urandom_range(0, 11);
                if (stall != 0)
                begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            m_tready <= 1'b1;
        end
    end

    // accepted verdicts
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            board.check_verdict(m_tdata);

    // watchdog on cycles with no accepted beat
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        tri_item_t it;
        int span;
        board = new();
        board.init();
        idle_cycles = 0;
        hold_rx = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extreme vertices with empty table at reset settings
        it = rand_test(65536);
        {it.ox, it.oy, it.dx, it.dy, it.ax, it.ay} =
            {32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sd0, 32'sd0};
        send_item(it, 0);
        it.ox = 0; it.oy = 0; it.dx = 0; it.dy = 0; it.ax = 0; it.ay = 0;
        send_item(it, 0);
        // right triangle past the mean bound: s = 4*msq, so the bound alone decides
        it.dx = 32'sd65536; it.dy = 0; it.ax = 0; it.ay = 32'sd65536;
        send_item(it, 0);
        // load extremes into the last slot (63) and slot 0
        it = rand_load(65536);
        it.idx = 6'd63; it.px = 32'sh7fffffff; it.py = 32'sh80000000;
        it.psize = 31'h7fffffff;
        send_item(it, 0);
        it.idx = 6'd0; it.px = 0; it.py = 0; it.psize = 0;
        send_item(it, 0);
        fill_table(65536, 0);
        drain();

        // directed: point near origin, zero gradient then zone on
        write_reg(CFG_MESH_SIZE, 31'd4 << 16);
        write_reg(CFG_POINT_COUNT, 7'd1);
        write_reg(CFG_GRADIENT, 31'd0);
        it = rand_test(65536);
        {it.ox, it.oy, it.dx, it.dy, it.ax, it.ay} =
            {32'sd0, 32'sd0, 32'sd131072, 32'sd0, 32'sd0, 32'sd131072};
        send_item(it, 0);
        drain();
        write_reg(CFG_GRADIENT, 31'h7fffffff);
        send_item(it, 0);
        drain();
        write_reg(CFG_POINT_COUNT, 7'd127);
        send_item(it, 0);
        drain();

        // random phases across several settings
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: begin write_reg(CFG_GRADIENT, 31'd65536);
                         write_reg(CFG_MESH_SIZE, 31'd8 << 16);
                         write_reg(CFG_POINT_COUNT, 7'd64); span = 1 << 18; end
                1: begin write_reg(CFG_GRADIENT, 31'd16384);
                         write_reg(CFG_POINT_COUNT, 7'd8); span = 1 << 18; end
                2: begin write_reg(CFG_GRADIENT, 31'h7fffffff);
                         write_reg(CFG_MESH_SIZE, 31'h7fffffff);
                         write_reg(CFG_POINT_COUNT, 7'd64); span = 1 << 30; end
                3: begin write_reg(CFG_GRADIENT, 31'd0);
                         write_reg(CFG_MESH_SIZE, 31'd0); span = 1 << 12; end
                4: begin write_reg(CFG_GRADIENT, 31'd4 << 16);
                         write_reg(CFG_MESH_SIZE, 31'd2 << 16);
                         write_reg(CFG_POINT_COUNT, 7'd33); span = 1 << 17; end
                5: begin write_reg(CFG_GRADIENT, 31'($urandom));
                         write_reg(CFG_MESH_SIZE, 31'($urandom_range(1, 1 << 22)));
                         write_reg(CFG_POINT_COUNT, 7'd100); span = 1 << 20; end
                6: begin write_reg(CFG_GRADIENT, 31'd1);
                         write_reg(CFG_POINT_COUNT, 7'd0); span = 1 << 16; end
                default: begin write_reg(CFG_GRADIENT, 31'd98304);
                         write_reg(CFG_MESH_SIZE, 31'd3 << 16);
                         write_reg(CFG_POINT_COUNT, 7'd64); span = 1 << 18; end
            endcase
            fill_table(span, 1);
            if (ph == 1)
                hold_rx = 1;
            for (int k = 0; k < 170; k++)
            begin
                if ($urandom_range(0, 4) == 0)
                    it = rand_load(span);
                else
                    it = rand_test(span);
                send_item(it, ph != 4);
            end
            // sender pause until every verdict is back
            drain();
        end
        drain();
        if (board.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
